@@ src/ddp_packet_to_led_frame_core_defines.svh @@
// assertion macros for the ddp led frame receiver
// expects clk and rst_n in the scope of the module that uses them
`ifndef DDP_PACKET_TO_LED_FRAME_CORE_DEFINES_SVH
`define DDP_PACKET_TO_LED_FRAME_CORE_DEFINES_SVH

// property checked at every rising clk edge, off while in reset
`define DDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen
`define DDP_ASSERT_NEVER(lbl, cond, msg) \
    `DDP_ASSERT(lbl, !(cond), msg)

`endif

@@ src/ddp_led_pkg.sv @@
// shared types, codes and helpers for the ddp led frame receiver
// no dependencies; used by ddp_packet_to_led_frame_core
package ddp_led_pkg;

    localparam int MAX_LEDS_DEF     = 1024;
    localparam int HEADER_BYTES_DEF = 10;

    localparam int NUM_LEDS_W  = 11;
    localparam int PIX_IDX_W   = 10;
    localparam int PIXEL_W     = 24;
    localparam int STATUS_W    = 3;
    localparam int SEQ_W       = 4;
    localparam int POS_W       = 17;
    localparam int BASE_W      = 31;
    localparam int LEN_W       = 16;
    localparam int TRI_W       = 15;

    localparam logic [POS_W-1:0] POS_MAX       = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_FLAGS     = 17'd0;
    localparam logic [POS_W-1:0] POS_SEQ       = 17'd1;
    localparam logic [POS_W-1:0] POS_OFF_FIRST = 17'd4;
    localparam logic [POS_W-1:0] POS_OFF_LAST  = 17'd7;
    localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd8;
    localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd9;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam logic [STATUS_W-1:0] STS_APPLIED   = 3'd0;
    localparam logic [STATUS_W-1:0] STS_SHORT_HDR = 3'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_VER   = 3'd2;
    localparam logic [STATUS_W-1:0] STS_TRUNCATED = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NO_LEDS   = 3'd4;

    localparam logic [1:0] VERSION_ONE = 2'b01;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    // floor(v / 3) = (v * 683) >> 11 for v < 768
    localparam logic [9:0] RECIP3       = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic                push;
        logic [SEQ_W-1:0]    seq;
        logic [PIXEL_W-1:0]  pixel;
    } result_t;

    typedef struct packed {
        logic [7:0] quo;
        logic [1:0] rem;
    } div3_t;

    // one byte of a long division by three, most significant byte first
    function automatic div3_t div3_step(input logic [1:0] rem_in, input logic [7:0] byte_in);
        logic [9:0]  v;
        logic [19:0] prod;
        logic [9:0]  three_q;
        div3_t       res;
        v        = {rem_in, byte_in};
        prod     = 20'(v) * 20'(RECIP3);
        res.quo  = prod[RECIP3_SHIFT+7:RECIP3_SHIFT];
        three_q  = {1'b0, res.quo, 1'b0} + {2'b00, res.quo};
        res.rem  = 2'(v - three_q);
        return res;
    endfunction

endpackage

@@ src/ddp_led_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module ddp_led_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ddp_packet_to_led_frame_core.sv @@
// ddp packet receiver that drives an led frame store
// depends on ddp_led_pkg, ddp_led_ram and ddp_packet_to_led_frame_core_defines.svh
//
// usage:
//   s_* stream carries one beat per packet byte (tuser = 0) or per pixel read
//   (tuser = 1); tlast marks the final byte of a packet. m_* stream returns one
//   beat per packet end (status) and one per pixel read (kind in tuser).
//   cfg_we/cfg_wdata write the led count; write it only while the block is idle.
// flow and throughput:
//   a packet byte gives no beat unless it is the last; the next byte can follow.
//   a pixel read holds s_tready low in S_READ while the frame ram read completes;
//   its beat passes the frame ram read and then the output register. a packet
//   end does the checks in S_FINISH, where a rejected packet loads its beat. an
//   applied packet copies its staged pixels at one per cycle, drains the last
//   write and then loads its beat; a blanking sweep of all MAX_LEDS entries comes
//   first when it is the first applied packet since the led count changed.
//   s_tready is low during a read, the checks, the copy and the blanking sweep.
// reset:
//   clears all control and header state and marks the frame as unsized, so
//   reads return black; there is no memory clearing pass after reset.
// stall:
//   results sit in an output register; while it is full and m_tready is low
//   no new beat is taken, so nothing is lost or repeated.
`include "ddp_packet_to_led_frame_core_defines.svh"

module ddp_packet_to_led_frame_core #(
    parameter int MAX_LEDS     = ddp_led_pkg::MAX_LEDS_DEF,
    parameter int HEADER_BYTES = ddp_led_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config register
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,     // num_leds
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,       // [7:0] data_byte, [17:8] pixel_index, rest zero
    input  logic        s_tlast,       // last_byte
    input  logic        s_tuser,       // opcode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [2:0] status, [3] push_frame, [7:4] sequence_res,
                                       // [15:8] red, [23:16] green, [31:24] blue
    output logic        m_tuser        // result_kind
);

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int PW    = ddp_led_pkg::POS_W;
    localparam int DW    = 33;   // destination arithmetic width

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_FINISH = 3'd2;
    localparam logic [2:0] S_CLEAR  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    localparam logic [PW-1:0]    HDR_POS   = PW'(HEADER_BYTES);
    localparam logic [DW-1:0]    MAX_D     = DW'(MAX_LEDS);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_LEDS);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_LEDS - 1);

    // control state
    logic [2:0]                           state_reg, state_next;
    logic [ddp_led_pkg::NUM_LEDS_W-1:0]   num_leds_reg, num_leds_next;
    logic                                 frame_sized_reg, frame_sized_next;
    // packet parse state
    logic [PW-1:0]                        pos_reg, pos_next;
    logic [7:0]                           flags_reg, flags_next;
    logic [ddp_led_pkg::SEQ_W-1:0]        seq_reg, seq_next;
    logic [ddp_led_pkg::BASE_W-1:0]       base_reg, base_next;     // header offset / 3
    logic [1:0]                           rem_reg, rem_next;       // running remainder
    logic [ddp_led_pkg::LEN_W-1:0]        plen_reg, plen_next;
    logic [15:0]                          partial_reg, partial_next;
    logic [1:0]                           phase_reg, phase_next;   // byte within triple
    logic [ddp_led_pkg::TRI_W-1:0]        tri_reg, tri_next;       // pixel number in packet
    logic [CNT_W-1:0]                     staged_cnt_reg, staged_cnt_next;
    // sweep state
    logic [AW-1:0]                        clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]                     commit_k_reg, commit_k_next;
    logic                                 pend_valid_reg, pend_valid_next;
    logic                                 pend_ok_reg, pend_ok_next;
    logic [AW-1:0]                        pend_addr_reg, pend_addr_next;
    logic                                 rd_ok_reg, rd_ok_next;
    // output register
    logic                                 out_valid_reg, out_valid_next;
    ddp_led_pkg::result_t                 out_reg, out_next;

    // memory ports
    logic                                 frame_we;
    logic [AW-1:0]                        frame_waddr;
    logic [ddp_led_pkg::PIXEL_W-1:0]      frame_wdata;
    logic [ddp_led_pkg::PIXEL_W-1:0]      frame_rdata;
    logic                                 stage_we;
    logic [ddp_led_pkg::PIXEL_W-1:0]      stage_wdata;
    logic [ddp_led_pkg::PIXEL_W-1:0]      stage_rdata;

    // misc combinational
    logic                                 in_acc;
    logic [7:0]                           in_byte;
    logic [ddp_led_pkg::PIX_IDX_W-1:0]    in_index;
    logic [DW-1:0]                        active_n;
    logic [DW-1:0]                        stage_dest;
    logic [DW-1:0]                        commit_dest;
    logic [PW-1:0]                        pkt_end_pos;
    logic [ddp_led_pkg::STATUS_W-1:0]     finish_sts;
    ddp_led_pkg::div3_t                   div_step;
    logic                                 pkt_clear;
    logic                                 out_load;
    ddp_led_pkg::result_t                 out_data;

    assign in_byte  = s_tdata[7:0];
    assign in_index = s_tdata[17:8];

    // new beats only while idle and the output slot is free or draining
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;

    // an led count above the store size acts as the store size
    assign active_n = (DW'(num_leds_reg) > MAX_D) ? MAX_D : DW'(num_leds_reg);

    assign stage_dest  = DW'(base_reg) + DW'(tri_reg);
    assign commit_dest = DW'(base_reg) + DW'(commit_k_reg);
    assign pkt_end_pos = HDR_POS + PW'(plen_reg);
    assign div_step    = ddp_led_pkg::div3_step(rem_reg, in_byte);
    assign stage_wdata = {partial_reg, in_byte};

    // packet end checks, in priority order
    always_comb
    begin
        if (pos_reg < HDR_POS)
        begin
            finish_sts = ddp_led_pkg::STS_SHORT_HDR;
        end
        else if (flags_reg[7:6] != ddp_led_pkg::VERSION_ONE)
        begin
            finish_sts = ddp_led_pkg::STS_BAD_VER;
        end
        else if (pos_reg < pkt_end_pos)
        begin
            finish_sts = ddp_led_pkg::STS_TRUNCATED;
        end
        else if (num_leds_reg == '0)
        begin
            finish_sts = ddp_led_pkg::STS_NO_LEDS;
        end
        else
        begin
            finish_sts = ddp_led_pkg::STS_APPLIED;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        num_leds_next    = num_leds_reg;
        frame_sized_next = frame_sized_reg;
        pos_next         = pos_reg;
        flags_next       = flags_reg;
        seq_next         = seq_reg;
        base_next        = base_reg;
        rem_next         = rem_reg;
        plen_next        = plen_reg;
        partial_next     = partial_reg;
        phase_next       = phase_reg;
        tri_next         = tri_reg;
        staged_cnt_next  = staged_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        commit_k_next    = commit_k_reg;
        pend_valid_next  = 1'b0;
        pend_ok_next     = 1'b0;
        pend_addr_next   = pend_addr_reg;
        rd_ok_next       = rd_ok_reg;
        frame_we         = 1'b0;
        frame_waddr      = pend_addr_reg;
        frame_wdata      = stage_rdata;
        stage_we         = 1'b0;
        pkt_clear        = 1'b0;
        out_load         = 1'b0;
        out_data         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_tuser == ddp_led_pkg::OP_READ))
                begin
                    rd_ok_next = frame_sized_reg && (DW'(in_index) < active_n);
                    state_next = S_READ;
                end
                else if (in_acc)
                begin
                    if (pos_reg == ddp_led_pkg::POS_FLAGS)
                    begin
                        flags_next = in_byte;
                    end
                    else if (pos_reg == ddp_led_pkg::POS_SEQ)
                    begin
                        seq_next = in_byte[3:0];
                    end
                    else if ((pos_reg >= ddp_led_pkg::POS_OFF_FIRST) &&
                             (pos_reg <= ddp_led_pkg::POS_OFF_LAST))
                    begin
                        // divide the big-endian offset by three a byte at a time
                        base_next = {base_reg[ddp_led_pkg::BASE_W-9:0], div_step.quo};
                        rem_next  = div_step.rem;
                    end
                    else if ((pos_reg == ddp_led_pkg::POS_LEN_HI) ||
                             (pos_reg == ddp_led_pkg::POS_LEN_LO))
                    begin
                        plen_next = {plen_reg[7:0], in_byte};
                    end
                    else if ((pos_reg >= HDR_POS) && (pos_reg < pkt_end_pos))
                    begin
                        if (phase_reg != ddp_led_pkg::PHASE_BLUE)
                        begin
                            partial_next = {partial_reg[7:0], in_byte};
                            phase_next   = phase_reg + 2'd1;
                        end
                        else
                        begin
                            phase_next = 2'd0;
                            tri_next   = tri_reg + 1'b1;
                            if ((stage_dest < MAX_D) && (staged_cnt_reg < MAX_CNT))
                            begin
                                stage_we        = 1'b1;
                                staged_cnt_next = staged_cnt_reg + 1'b1;
                            end
                        end
                    end
                    if (pos_reg != ddp_led_pkg::POS_MAX)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_READ:
            begin
                out_load       = 1'b1;
                out_data.kind  = ddp_led_pkg::KIND_PIXEL;
                out_data.pixel = rd_ok_reg ? frame_rdata : '0;
                state_next     = S_IDLE;
            end

            S_FINISH:
            begin
                if (finish_sts == ddp_led_pkg::STS_APPLIED)
                begin
                    state_next = frame_sized_reg ? S_COMMIT : S_CLEAR;
                end
                else
                begin
                    out_load        = 1'b1;
                    out_data.kind   = ddp_led_pkg::KIND_STATUS;
                    out_data.status = finish_sts;
                    if (finish_sts != ddp_led_pkg::STS_SHORT_HDR &&
                        finish_sts != ddp_led_pkg::STS_BAD_VER)
                    begin
                        out_data.seq = seq_reg;
                    end
                    pkt_clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                // blank the whole frame once after a resize
                frame_we    = 1'b1;
                frame_waddr = clr_cnt_reg;
                frame_wdata = '0;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next     = '0;
                    frame_sized_next = 1'b1;
                    state_next       = S_COMMIT;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end

            S_COMMIT:
            begin
                // read staged pixel k, write it to base + k in the next cycle
                frame_we = pend_valid_reg && pend_ok_reg;
                if (commit_k_reg < staged_cnt_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_ok_next    = commit_dest < active_n;
                    pend_addr_next  = AW'(commit_dest);
                    commit_k_next   = commit_k_reg + 1'b1;
                end
                else if (!pend_valid_reg)
                begin
                    commit_k_next   = '0;
                    out_load        = 1'b1;
                    out_data.kind   = ddp_led_pkg::KIND_STATUS;
                    out_data.status = ddp_led_pkg::STS_APPLIED;
                    out_data.push   = flags_reg[0];
                    out_data.seq    = seq_reg;
                    pkt_clear       = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pkt_clear)
        begin
            pos_next        = '0;
            flags_next      = '0;
            seq_next        = '0;
            base_next       = '0;
            rem_next        = '0;
            plen_next       = '0;
            partial_next    = '0;
            phase_next      = '0;
            tri_next        = '0;
            staged_cnt_next = '0;
        end

        // a new size invalidates the frame contents
        if (cfg_we)
        begin
            num_leds_next = cfg_wdata;
            if (cfg_wdata != num_leds_reg)
            begin
                frame_sized_next = 1'b0;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = out_data;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_tready;
            out_next       = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_leds_reg    <= '0;
            frame_sized_reg <= 1'b0;
            pos_reg         <= '0;
            flags_reg       <= '0;
            seq_reg         <= '0;
            base_reg        <= '0;
            rem_reg         <= '0;
            plen_reg        <= '0;
            partial_reg     <= '0;
            phase_reg       <= '0;
            tri_reg         <= '0;
            staged_cnt_reg  <= '0;
            clr_cnt_reg     <= '0;
            commit_k_reg    <= '0;
            pend_valid_reg  <= 1'b0;
            pend_ok_reg     <= 1'b0;
            rd_ok_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            num_leds_reg    <= num_leds_next;
            frame_sized_reg <= frame_sized_next;
            pos_reg         <= pos_next;
            flags_reg       <= flags_next;
            seq_reg         <= seq_next;
            base_reg        <= base_next;
            rem_reg         <= rem_next;
            plen_reg        <= plen_next;
            partial_reg     <= partial_next;
            phase_reg       <= phase_next;
            tri_reg         <= tri_next;
            staged_cnt_reg  <= staged_cnt_next;
            clr_cnt_reg     <= clr_cnt_next;
            commit_k_reg    <= commit_k_next;
            pend_valid_reg  <= pend_valid_next;
            pend_ok_reg     <= pend_ok_next;
            rd_ok_reg       <= rd_ok_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

    // frame store: written by the blanking sweep and the commit, read by pixel reads
    ddp_led_ram #(
        .WIDTH  (ddp_led_pkg::PIXEL_W),
        .DEPTH  (MAX_LEDS),
        .ADDR_W (AW)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (AW'(in_index)),
        .rdata (frame_rdata)
    );

    // staging store: filled during the packet, drained by the commit
    ddp_led_ram #(
        .WIDTH  (ddp_led_pkg::PIXEL_W),
        .DEPTH  (MAX_LEDS),
        .ADDR_W (AW)
    ) u_stage_ram (
        .clk   (clk),
        .we    (stage_we),
        .waddr (AW'(staged_cnt_reg)),
        .wdata (stage_wdata),
        .raddr (AW'(commit_k_reg)),
        .rdata (stage_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {out_reg.pixel[7:0], out_reg.pixel[15:8], out_reg.pixel[23:16],
                       out_reg.seq, out_reg.push, out_reg.status};

    `DDP_ASSERT(a_out_no_overwrite, out_load |-> (!out_valid_reg || $past(m_tready) || (state_reg == S_READ) || (state_reg == S_FINISH) || (state_reg == S_COMMIT)), "result loaded over a pending beat")
    `DDP_ASSERT(a_frame_we_sweep, frame_we |-> ((state_reg == S_CLEAR) || (state_reg == S_COMMIT)), "frame write outside a sweep")
    `DDP_ASSERT(a_stage_in_range, stage_we |-> (staged_cnt_reg < MAX_CNT), "staging write past the end")
    `DDP_ASSERT(a_commit_sized, (state_reg == S_COMMIT) |-> frame_sized_reg, "commit into an unsized frame")
    `DDP_ASSERT_NEVER(a_pend_outside, pend_valid_reg && (state_reg != S_COMMIT), "pending commit write outside commit")

endmodule

@@ test/ddp_packet_to_led_frame_core_test.sv @@
// self-checking testbench for ddp_packet_to_led_frame_core: ddp packets and pixel
// reads go in as stream beats, status and pixel beats are checked against a predictor
// depends on ddp_led_pkg and the rtl of ddp_packet_to_led_frame_core
module ddp_packet_to_led_frame_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEDS        = ddp_led_pkg::MAX_LEDS_DEF;
    localparam int HEADER_BYTES    = ddp_led_pkg::HEADER_BYTES_DEF;
    localparam int PW              = ddp_led_pkg::POS_W;
    localparam int BYTES_PER_PIXEL = 3;
    // idle margin before a register write and at the end of the run
    localparam int SETTLE_CYCLES   = 2 * MAX_LEDS + 64;
    localparam int QUIET_LIMIT     = 20000;
    localparam int PHASE_BEATS     = 65;
    localparam logic [PW-1:0] HDR_LEN = PW'(HEADER_BYTES);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // [7:0] data_byte, [17:8] pixel_index, rest zero
    logic        s_tlast = 1'b0;    // last_byte
    logic        s_tuser = 1'b0;    // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [2:0] status, [3] push_frame, [7:4] sequence_res,
                                    // [15:8] red, [23:16] green, [31:24] blue
    logic        m_tuser;           // result_kind

    ddp_packet_to_led_frame_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state: register, packet parser, staging and frame copies
    logic [10:0]                     led_cfg = '0;
    logic [PW-1:0]                   rx_pos;
    logic [7:0]                      rx_flags;
    logic [3:0]                      rx_seq;
    logic [31:0]                     rx_offset;
    logic [15:0]                     rx_len;
    logic [15:0]                     rx_partial;
    logic [10:0]                     staged_n;
    logic [ddp_led_pkg::PIXEL_W-1:0] staged_px [MAX_LEDS];
    logic [ddp_led_pkg::PIXEL_W-1:0] frame_px [MAX_LEDS];
    bit                              frame_ready = 1'b0;

    ddp_led_pkg::result_t pending_results [$];
    logic [7:0]  pkt_bytes [$];
    int          beats_sent = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    // idling controls shared by the sender and the result stall driver
    bit          idling_on = 1'b0;
    int          gap_pct = 20;
    int          stall_pct = 20;
    int          stall_left = 0;

    function automatic int active_leds();
        return (int'(led_cfg) > MAX_LEDS) ? MAX_LEDS : int'(led_cfg);
    endfunction

    function automatic void drop_packet_state();
        rx_pos     = '0;
        rx_flags   = '0;
        rx_seq     = '0;
        rx_offset  = '0;
        rx_len     = '0;
        rx_partial = '0;
        staged_n   = '0;
    endfunction

    // parse one packet byte at the current position
    function automatic void absorb_byte(logic [7:0] b);
        logic [PW-1:0]    q;
        longint unsigned  dest;
        if (rx_pos == ddp_led_pkg::POS_FLAGS)
            rx_flags = b;
        else if (rx_pos == ddp_led_pkg::POS_SEQ)
            rx_seq = b[3:0];
        else if (rx_pos >= ddp_led_pkg::POS_OFF_FIRST && rx_pos <= ddp_led_pkg::POS_OFF_LAST)
            rx_offset = {rx_offset[23:0], b};
        else if (rx_pos == ddp_led_pkg::POS_LEN_HI || rx_pos == ddp_led_pkg::POS_LEN_LO)
            rx_len = {rx_len[7:0], b};
        else if (rx_pos >= HDR_LEN)
        begin
            q = rx_pos - HDR_LEN;
            if (q < PW'(rx_len))
            begin
                if ((q % BYTES_PER_PIXEL) < 2)
                    rx_partial = {rx_partial[7:0], b};
                else
                begin
                    dest = 64'(rx_offset / BYTES_PER_PIXEL) + 64'(q / BYTES_PER_PIXEL);
                    if (dest < 64'(MAX_LEDS) && int'(staged_n) < MAX_LEDS)
                    begin
                        staged_px[staged_n] = {rx_partial, b};
                        staged_n = staged_n + 1'b1;
                    end
                end
            end
        end
        if (rx_pos != ddp_led_pkg::POS_MAX)
            rx_pos = rx_pos + 1'b1;
    endfunction

    // packet end: status checks in priority order, commit on success
    function automatic ddp_led_pkg::result_t close_packet();
        ddp_led_pkg::result_t r = '0;
        longint unsigned      base;
        r.kind = ddp_led_pkg::KIND_STATUS;
        if (rx_pos < HDR_LEN)
            r.status = ddp_led_pkg::STS_SHORT_HDR;
        else if (rx_flags[7:6] != ddp_led_pkg::VERSION_ONE)
            r.status = ddp_led_pkg::STS_BAD_VER;
        else if (int'(rx_pos) < HEADER_BYTES + int'(rx_len))
            r.status = ddp_led_pkg::STS_TRUNCATED;
        else if (led_cfg == '0)
            r.status = ddp_led_pkg::STS_NO_LEDS;
        else
        begin
            r.status = ddp_led_pkg::STS_APPLIED;
            if (!frame_ready)
            begin
                foreach (frame_px[i])
                    frame_px[i] = '0;
                frame_ready = 1'b1;
            end
            base = 64'(rx_offset / BYTES_PER_PIXEL);
            for (int k = 0; k < int'(staged_n); k++)
                if (base + 64'(k) < 64'(active_leds()))
                    frame_px[base + 64'(k)] = staged_px[k];
        end
        if (r.status == ddp_led_pkg::STS_APPLIED)
            r.push = rx_flags[0];
        if (r.status == ddp_led_pkg::STS_APPLIED || r.status == ddp_led_pkg::STS_TRUNCATED ||
            r.status == ddp_led_pkg::STS_NO_LEDS)
            r.seq = rx_seq;
        drop_packet_state();
        return r;
    endfunction

    function automatic ddp_led_pkg::result_t stored_pixel(logic [9:0] idx);
        ddp_led_pkg::result_t r = '0;
        r.kind = ddp_led_pkg::KIND_PIXEL;
        if (frame_ready && int'(idx) < active_leds())
            r.pixel = frame_px[idx];
        return r;
    endfunction

    // drive one input beat, wait for the handshake, then update the predictor
    task automatic send_beat(input logic op, input logic [7:0] data, input logic last,
                             input logic [9:0] idx);
        if (idling_on && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {6'b0, idx, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
        if (op == ddp_led_pkg::OP_READ)
            pending_results.push_back(stored_pixel(idx));
        else
        begin
            absorb_byte(data);
            if (last)
                pending_results.push_back(close_packet());
        end
    endtask

    // the last mark and the byte lane carry junk on reads, they must be ignored
    task automatic read_pixel(input logic [9:0] idx);
        send_beat(ddp_led_pkg::OP_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    function automatic logic [9:0] random_index();
        int top;
        top = active_leds() + 2;
        if (top > MAX_LEDS - 1 || $urandom_range(0, 3) == 0)
            top = MAX_LEDS - 1;
        return 10'($urandom_range(0, top));
    endfunction

    function automatic logic [7:0] good_flags(logic push);
        return {ddp_led_pkg::VERSION_ONE, 5'($urandom), push};
    endfunction

    function automatic void start_packet(logic [7:0] flags, logic [3:0] seq,
                                         logic [31:0] off, logic [15:0] len);
        pkt_bytes.delete();
        pkt_bytes.push_back(flags);
        pkt_bytes.push_back({4'($urandom), seq});
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(off[31:24]);
        pkt_bytes.push_back(off[23:16]);
        pkt_bytes.push_back(off[15:8]);
        pkt_bytes.push_back(off[7:0]);
        pkt_bytes.push_back(len[15:8]);
        pkt_bytes.push_back(len[7:0]);
    endfunction

    function automatic void add_bytes(int count);
        repeat (count) pkt_bytes.push_back(8'($urandom));
    endfunction

    function automatic void trim_packet(int count);
        while (pkt_bytes.size() > count)
            void'(pkt_bytes.pop_back());
    endfunction

    // send the built packet, with reads slipped in between its bytes now and then
    task automatic send_packet(input int read_pct);
        for (int i = 0; i < pkt_bytes.size(); i++)
        begin
            if ($urandom_range(0, 99) < read_pct)
                read_pixel(random_index());
            send_beat(ddp_led_pkg::OP_BYTE, pkt_bytes[i], i == pkt_bytes.size() - 1,
                      10'($urandom));
        end
    endtask

    // register writes only once every result is out and the block is idle
    task automatic write_num_leds(input logic [10:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (value != led_cfg)
            frame_ready = 1'b0;
        led_cfg = value;
    endtask

    task automatic test_after_reset();
        // unsized frame reads black, no leds rejects a good packet
        read_pixel(10'd0);
        read_pixel(10'd1023);
        start_packet(good_flags(1'b1), 4'h5, 32'd0, 16'd3);
        add_bytes(3);
        send_packet(0);
        start_packet(good_flags(1'b1), 4'h5, 32'd0, 16'd3);
        trim_packet(1);
        send_packet(0);
    endtask

    task automatic test_status_codes();
        write_num_leds(11'd4);
        // header cut one byte short
        start_packet(good_flags(1'b1), 4'h3, 32'd0, 16'd12);
        trim_packet(HEADER_BYTES - 1);
        send_packet(0);
        // versions 0, 2 and 3
        start_packet({2'b00, 6'h01}, 4'h6, 32'd0, 16'd0);
        send_packet(0);
        start_packet({2'b10, 6'h3F}, 4'h7, 32'd0, 16'd0);
        send_packet(0);
        start_packet({2'b11, 6'h00}, 4'h8, 32'd0, 16'd0);
        send_packet(0);
        // payload shorter than the length field
        start_packet(good_flags(1'b1), 4'hA, 32'd0, 16'd6);
        add_bytes(3);
        send_packet(0);
        // four pixels plus trailing junk
        start_packet(good_flags(1'b1), 4'hF, 32'd0, 16'd12);
        add_bytes(16);
        send_packet(0);
        for (int i = 0; i <= 4; i++)
            read_pixel(10'(i));
        // offset not a multiple of three, incomplete last triple, reads mid packet
        start_packet(good_flags(1'b0), 4'h0, 32'd7, 16'd5);
        add_bytes(5);
        send_packet(50);
        // second pixel lands on the led count and is dropped
        start_packet(good_flags(1'b1), 4'h1, 32'd9, 16'd6);
        add_bytes(6);
        send_packet(0);
        // destination far past the store
        start_packet(good_flags(1'b1), 4'h2, 32'hFFFF_FFFF, 16'd3);
        add_bytes(3);
        send_packet(0);
        start_packet(good_flags(1'b0), 4'h4, 32'd0, 16'd0);
        send_packet(0);
        read_pixel(10'd2);
        read_pixel(10'd3);
        read_pixel(10'd1023);
    endtask

    task automatic test_resize();
        write_num_leds(11'd1024);
        read_pixel(10'd0);
        // first packet after the resize blanks the frame, then fills its top end
        start_packet(good_flags(1'b1), 4'h9, 32'(BYTES_PER_PIXEL * (MAX_LEDS - 8)),
                     16'(BYTES_PER_PIXEL * 8));
        add_bytes(BYTES_PER_PIXEL * 8);
        send_packet(0);
        read_pixel(10'd0);
        read_pixel(10'(MAX_LEDS - 8));
        read_pixel(10'd1023);
        // last pixel runs off the end of the store
        start_packet(good_flags(1'b1), 4'hB, 32'(BYTES_PER_PIXEL * 1020), 16'd15);
        add_bytes(15);
        send_packet(0);
        read_pixel(10'd1020);
        read_pixel(10'd1023);
        // oversize count acts as the store size, first packet blanks the frame
        write_num_leds(11'd2047);
        read_pixel(10'd1023);
        start_packet(good_flags(1'b0), 4'hC, 32'(BYTES_PER_PIXEL * 10), 16'd3);
        add_bytes(3);
        send_packet(0);
        read_pixel(10'd1023);
        read_pixel(10'd10);
        // same value again keeps the frame
        write_num_leds(11'd2047);
        read_pixel(10'd10);
        write_num_leds(11'd1);
        start_packet(good_flags(1'b1), 4'hD, 32'd0, 16'd6);
        add_bytes(6);
        send_packet(0);
        read_pixel(10'd0);
        read_pixel(10'd1);
        write_num_leds(11'd0);
        read_pixel(10'd0);
        start_packet(good_flags(1'b1), 4'hE, 32'd0, 16'd3);
        add_bytes(3);
        send_packet(0);
    endtask

    task automatic random_packet();
        int          pick;
        int          plen;
        int          payload;
        logic [31:0] off;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            off = 32'(BYTES_PER_PIXEL * $urandom_range(0, active_leds())) + $urandom_range(0, 2);
        else if (pick < 80)
            off = 32'(BYTES_PER_PIXEL * (MAX_LEDS - $urandom_range(0, 12)))
                  + $urandom_range(0, 2);
        else if (pick < 90)
            off = $urandom();
        else
            off = $urandom_range(0, 6200);
        pick = $urandom_range(0, 99);
        if (pick < 85)
            plen = BYTES_PER_PIXEL * $urandom_range(0, 6)
                   + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
        else if (pick < 95)
            plen = $urandom_range(0, 60);
        else
            plen = $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        if (pick < 92)
            start_packet(good_flags(1'($urandom)), 4'($urandom), off, 16'(plen));
        else
            start_packet({2'($urandom_range(2, 3)) ^ {1'b0, 1'($urandom)}, 6'($urandom)},
                         4'($urandom), off, 16'(plen));
        pick = $urandom_range(0, 99);
        if (plen > 300)
            payload = $urandom_range(0, 30);
        else if (pick < 75)
            payload = plen + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
        else if (pick < 90 && plen > 0)
            payload = $urandom_range(0, plen - 1);
        else
            payload = plen;
        add_bytes(payload);
        if ($urandom_range(0, 99) < 6)
            trim_packet($urandom_range(1, HEADER_BYTES - 1));
        send_packet(5);
    endtask

    task automatic test_random_traffic();
        logic [10:0] leds [6];
        int          stop_at;
        bit          quiet;
        leds = '{11'd3, 11'($urandom_range(2, 1023)), 11'd1024, 11'd1, 11'd2047,
                 11'($urandom_range(5, 1024))};
        for (int p = 0; p < 6; p++)
        begin
            // the last phase runs with no idling on either side
            quiet = (p == 5);
            write_num_leds(leds[p]);
            idling_on = !quiet;
            gap_pct   = $urandom_range(5, 40);
            stall_pct = $urandom_range(5, 40);
            stop_at   = beats_sent + PHASE_BEATS;
            while (beats_sent < stop_at)
            begin
                if (!quiet && $urandom_range(0, 9) == 0)
                    idling_on = !idling_on;
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) read_pixel(random_index());
                else
                    random_packet();
            end
        end
    endtask

    // result side back pressure in bursts, timed by the stall_left countdown
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (idling_on && $urandom_range(0, 99) < stall_pct)
        begin
            m_tready   <= 1'b0;
            stall_left <= int'($urandom_range(0, 5));
        end
        else
            m_tready <= 1'b1;
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : check_results
        ddp_led_pkg::result_t got;
        ddp_led_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind   = m_tuser;
            got.status = m_tdata[2:0];
            got.push   = m_tdata[3];
            got.seq    = m_tdata[7:4];
            got.pixel  = {m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
            want = '0;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected beat: kind=%0d sts=%0d push=%0d seq=%0d pix=%06h",
                             got.kind, got.status, got.push, got.seq, got.pixel);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.status !== want.status ||
                    got.push !== want.push || got.seq !== want.seq ||
                    got.pixel !== want.pixel)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch at %0t: want kind=%0d sts=%0d push=%0d seq=%0d pix=%06h",
                                 $realtime, want.kind, want.status, want.push, want.seq,
                                 want.pixel);
                        $display("    got kind=%0d sts=%0d push=%0d seq=%0d pix=%06h",
                                 got.kind, got.status, got.push, got.seq, got.pixel);
                    end
                end
            end
        end
    end

    // watchdog on cycles where neither stream moves a beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        drop_packet_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_status_codes();
        test_resize();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // catch any stray beats after the last expected one
        repeat (SETTLE_CYCLES) @(posedge clk);
        fail_count += pending_results.size();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
